### hdl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// shared constants and types for the radix sorter
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DIGIT_BITS_DEF = 8;
    localparam int WORD_W         = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_FIXNEG,
        ST_FIXPOS,
        ST_DRAIN
    } t_state;

endpackage

### hdl/double_radix_sorter_top.sv
// ----------------------------------------------------------------------------
// double_radix_sorter_top
// lsd radix sorter for binary64 bit patterns
// ----------------------------------------------------------------------------
// Collects a batch of up to CAPACITY 64-bit patterns (one per input transfer,
// last_in closes the batch; items past capacity are dropped and flagged on
// every result of the batch), then sorts them with stable least significant
// digit passes of DIGIT_BITS bits and emits them in ascending numeric order,
// sign-set values first (so -0.0 precedes +0.0). With B = 2^DIGIT_BITS bins
// and n stored elements each pass takes a bin clear sweep over the B bins, a
// count sweep (source read, bin read, bin write per element), a prefix sweep
// over the bins and a scatter sweep (source read, bin read, then bin write
// and element write per element); both element sweeps handle one element at
// a time. After the passes the sign fix takes two sweeps over the elements,
// negatives first, and the drain moves one result at a time into the output
// register, holding while the receiver stalls.
// Input is stalled from the closing transfer until the last result has been
// loaded into the output register.
module double_radix_sorter_top #(
    parameter int CAPACITY   = drs_pkg::CAPACITY_DEF,
    parameter int DIGIT_BITS = drs_pkg::DIGIT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value_bits,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_sorted_bits,
    output logic        o_last_out,
    output logic        o_overflow
);
    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int BINS   = 1 << DIGIT_BITS;
    localparam int NPASS  = (64 + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW     = $clog2(NPASS + 1);
    localparam int IW     = (CW > DIGIT_BITS + 1) ? CW : DIGIT_BITS + 1;

    drs_pkg::t_state r_state, n_state;

    logic [CW-1:0]         r_count;  // element count
    logic                  r_drop;   // dropped flag
    logic [PW-1:0]         r_pass;
    logic                  r_sel;    // 0: src is buffer a
    logic [IW-1:0]         r_idx;    // sweep index
    logic [IW-1:0]         r_idx2;   // prefix index of the previous cycle
    logic                  r_vld2;   // source / bin read data valid
    logic                  r_phase;  // bin update step of count and scatter
    logic [CW-1:0]         r_total;  // prefix total / write pointer
    logic [63:0]           r_hold;   // element being counted or scattered
    logic [DIGIT_BITS-1:0] r_dig;    // its digit

    // buffers
    logic          a_we, b_we;
    logic [AW-1:0] a_wa, b_wa, a_ra, b_ra;
    logic [63:0]   a_wd, b_wd, a_rd, b_rd;
    // bins
    logic                  c_we;
    logic [DIGIT_BITS-1:0] c_wa, c_ra;
    logic [CW-1:0]         c_wd, c_rd;

    drs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_buf_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(a_ra), .o_rdata(a_rd));
    drs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_buf_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(b_ra), .o_rdata(b_rd));
    drs_ram #(.WIDTH(CW), .DEPTH(BINS)) u_bins (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));

    // source data seen in the cycle after the read address
    logic [63:0] src_rd;
    logic [63:0] src_sh;
    logic [DIGIT_BITS-1:0] dig;
    assign src_rd = r_sel ? b_rd : a_rd;
    assign src_sh = src_rd >> (32'(r_pass) * DIGIT_BITS);
    assign dig    = src_sh[DIGIT_BITS-1:0];

    // output holding register
    logic        r_ovld;
    logic [63:0] r_obits;
    logic        r_olast;
    logic        r_oovf;
    logic        out_free;
    assign out_free = !r_ovld || !i_stall;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != drs_pkg::ST_LOAD);

    logic [IW-1:0] cnt_ext;
    logic [IW-1:0] last_idx;
    logic issue_done;   // sign fix issue index reached the element count
    logic elem_last;    // sweep index is on the last element
    logic issue;        // sign fix issues a source read this cycle
    logic fix_wr;       // sign fix writes the returned element
    logic drain_load;   // drain moves an element into the output register
    assign cnt_ext    = IW'(r_count);
    assign last_idx   = cnt_ext - IW'(1);
    assign issue_done = (r_idx >= cnt_ext);
    assign elem_last  = (r_idx == last_idx);
    assign issue      = (r_state inside {drs_pkg::ST_FIXNEG, drs_pkg::ST_FIXPOS})
                        && !issue_done;
    assign fix_wr     = r_vld2 && (src_rd[63] == (r_state == drs_pkg::ST_FIXNEG));
    assign drain_load = (r_state == drs_pkg::ST_DRAIN) && r_vld2 && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            drs_pkg::ST_LOAD:
                if (in_acc && i_last_in) begin
                    n_state = drs_pkg::ST_CLEAR;
                end
            drs_pkg::ST_CLEAR:
                if (r_idx == IW'(BINS - 1)) begin
                    n_state = drs_pkg::ST_COUNT;
                end
            drs_pkg::ST_COUNT:
                if (r_phase && elem_last) begin
                    n_state = drs_pkg::ST_PREFIX;
                end
            drs_pkg::ST_PREFIX:
                if (r_vld2 && r_idx == IW'(BINS)) begin
                    n_state = drs_pkg::ST_SCATTER;
                end
            drs_pkg::ST_SCATTER:
                if (r_phase && elem_last) begin
                    n_state = (r_pass == PW'(NPASS - 1)) ? drs_pkg::ST_FIXNEG
                                                         : drs_pkg::ST_CLEAR;
                end
            drs_pkg::ST_FIXNEG:
                if (issue_done && !r_vld2) begin
                    n_state = drs_pkg::ST_FIXPOS;
                end
            drs_pkg::ST_FIXPOS:
                if (issue_done && !r_vld2) begin
                    n_state = drs_pkg::ST_DRAIN;
                end
            drs_pkg::ST_DRAIN:
                if (drain_load && elem_last) begin
                    n_state = drs_pkg::ST_LOAD;
                end
            default: n_state = drs_pkg::ST_LOAD;
        endcase
    end

    // memory control; writes go to the buffer that is not the source, but for loading, which fills buffer a
    always_comb begin
        a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        a_wa = r_total[AW-1:0]; b_wa = r_total[AW-1:0];
        a_wd = src_rd; b_wd = src_rd;
        a_ra = r_idx[AW-1:0]; b_ra = r_idx[AW-1:0];
        c_wa = r_dig; c_ra = dig; c_wd = c_rd + CW'(1);
        case (r_state)
            drs_pkg::ST_LOAD: begin
                a_we = in_acc && (r_count < CW'(CAPACITY));
                a_wa = r_count[AW-1:0];
                a_wd = i_value_bits;
            end
            drs_pkg::ST_CLEAR: begin
                c_we = 1'b1;
                c_wa = r_idx[DIGIT_BITS-1:0];
                c_wd = '0;
            end
            drs_pkg::ST_COUNT: begin
                // bin read from the returned digit, bin write in the following cycle
                c_we = r_phase;
            end
            drs_pkg::ST_PREFIX: begin
                c_ra = r_idx[DIGIT_BITS-1:0];
                c_we = r_vld2;
                c_wa = r_idx2[DIGIT_BITS-1:0];
                c_wd = r_total;
            end
            drs_pkg::ST_SCATTER: begin
                c_we = r_phase;
                if (r_sel) begin
                    a_we = r_phase; a_wa = c_rd[AW-1:0]; a_wd = r_hold;
                end else begin
                    b_we = r_phase; b_wa = c_rd[AW-1:0]; b_wd = r_hold;
                end
            end
            drs_pkg::ST_FIXNEG: begin
                // negatives are read from the top down
                a_ra = AW'(last_idx - r_idx);
                b_ra = AW'(last_idx - r_idx);
                if (r_sel) begin
                    a_we = fix_wr;
                end else begin
                    b_we = fix_wr;
                end
            end
            drs_pkg::ST_FIXPOS: begin
                if (r_sel) begin
                    a_we = fix_wr;
                end else begin
                    b_we = fix_wr;
                end
            end
            default: ;
        endcase
    end

    // outputs
    assign o_valid       = r_ovld;
    assign o_sorted_bits = r_obits;
    assign o_last_out    = r_olast;
    assign o_overflow    = r_oovf;

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drs_pkg::ST_LOAD;
            r_count <= '0; r_drop <= 1'b0; r_pass <= '0; r_sel <= 1'b0;
            r_idx <= '0; r_idx2 <= '0; r_vld2 <= 1'b0; r_phase <= 1'b0;
            r_total <= '0; r_hold <= '0; r_dig <= '0;
            r_ovld <= 1'b0; r_obits <= '0; r_olast <= 1'b0; r_oovf <= 1'b0;
        end else begin
            r_state <= n_state;
            if (drain_load) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                drs_pkg::ST_LOAD: begin
                    if (in_acc) begin
                        if (r_count < CW'(CAPACITY)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                    r_idx <= '0; r_pass <= '0; r_sel <= 1'b0;
                    r_vld2 <= 1'b0; r_phase <= 1'b0;
                end
                drs_pkg::ST_CLEAR: begin
                    r_idx <= (r_idx == IW'(BINS - 1)) ? '0 : r_idx + IW'(1);
                    r_total <= '0;
                end
                drs_pkg::ST_COUNT, drs_pkg::ST_SCATTER: begin
                    // three steps per element: read src, read bin, write bin
                    if (r_state == drs_pkg::ST_SCATTER) begin
                        r_total <= '0;
                    end
                    if (r_vld2) begin
                        r_vld2  <= 1'b0;
                        r_phase <= 1'b1;
                        r_hold  <= src_rd;
                        r_dig   <= dig;
                    end else if (r_phase) begin
                        r_phase <= 1'b0;
                        r_idx   <= elem_last ? '0 : r_idx + IW'(1);
                        if (elem_last && r_state == drs_pkg::ST_SCATTER) begin
                            r_pass <= r_pass + PW'(1);
                            r_sel  <= !r_sel;
                        end
                    end else begin
                        r_vld2 <= 1'b1;
                    end
                end
                drs_pkg::ST_PREFIX: begin
                    if (r_vld2) begin
                        r_total <= r_total + c_rd;
                    end
                    r_vld2 <= (r_idx < IW'(BINS));
                    r_idx2 <= r_idx;
                    if (r_vld2 && r_idx == IW'(BINS)) begin
                        r_idx <= '0;
                    end else if (r_idx < IW'(BINS)) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                drs_pkg::ST_FIXNEG, drs_pkg::ST_FIXPOS: begin
                    r_vld2 <= issue;
                    if (issue) begin
                        r_idx <= r_idx + IW'(1);
                    end else if (!r_vld2) begin
                        r_idx <= '0;
                    end
                    if (fix_wr) begin
                        r_total <= r_total + CW'(1);
                    end
                    if (r_state == drs_pkg::ST_FIXPOS && !issue && !r_vld2) begin
                        r_sel <= !r_sel;
                    end
                end
                drs_pkg::ST_DRAIN: begin
                    // read address stays on r_idx until its element is taken
                    if (!r_vld2) begin
                        r_vld2 <= 1'b1;
                    end else if (out_free) begin
                        r_vld2  <= 1'b0;
                        r_obits <= src_rd;
                        r_olast <= elem_last;
                        r_oovf  <= r_drop;
                        if (elem_last) begin
                            r_idx <= '0; r_count <= '0; r_drop <= 1'b0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### hdl/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module drs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker
// port level checks for the radix sorter
// ----------------------------------------------------------------------------
module drs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_sorted_bits,
    input logic        o_last_out
);
    // input is closed while a batch still has results to come
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |-> o_stall) else $error("input open during output");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sorted_bits) && $stable(o_last_out)))
        else $error("stalled result changed");

    // a stalled input transfer stays offered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> i_valid) else $error("stalled input withdrawn");

    // no output right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output after reset");
endmodule

bind double_radix_sorter_top drs_checker u_drs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_sorted_bits(o_sorted_bits),
    .o_last_out(o_last_out));

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the binary64 radix sorter
// ----------------------------------------------------------------------------
// Batches of bit patterns go in through a queue-fed driver. A built-in
// ordering predictor works out the sorted batch when the closing transfer is
// accepted, and a monitor compares every result transfer with it. Both sides
// idle in random bursts, the receiver holds off once for a long stretch, and
// the last part of the run has no idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAP       = drs_pkg::CAPACITY_DEF;
    localparam int LIMIT     = 400000;
    localparam int LONG_HOLD = 6000;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } t_elem;

    typedef struct packed {
        logic [63:0] bits;
        logic        last;
        logic        ovf;
    } t_sorted;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [63:0] i_value_bits = '0;
    logic        i_last_in    = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [63:0] o_sorted_bits;
    logic        o_last_out;
    logic        o_overflow;

    double_radix_sorter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value_bits (i_value_bits),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sorted_bits(o_sorted_bits),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

    t_elem       pending_q[$];
    t_sorted     sorted_q[$];
    logic [63:0] batch_vals[$];
    bit          batch_dropped = 1'b0;
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;      // no idling in the final stretch
    bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
    bit          hold_done;
    int          in_gap, out_gap, hold_cnt;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // ascending numeric order of binary64 patterns, sign bit picks negatives
    function automatic bit ranks_before(logic [63:0] a, logic [63:0] b);
        if (a[63] != b[63]) return a[63];
        if (a[63]) return a[62:0] > b[62:0];
        return a[62:0] < b[62:0];
    endfunction

    task automatic add_item(logic [63:0] v, bit l);
        t_elem e;
        e.value = v;
        e.last  = l;
        pending_q.insert(pending_q.size(), e);
    endtask

    task automatic add_expected(logic [63:0] v, bit l, bit ovf);
        t_sorted s;
        s.bits = v;
        s.last = l;
        s.ovf  = ovf;
        sorted_q.insert(sorted_q.size(), s);
    endtask

    // stable insertion sort of the collected batch into the expected store
    task automatic sort_batch_into_expected();
        logic [63:0] vals[$];
        logic [63:0] t;
        int j;
        vals = batch_vals;
        for (int k = 1; k < vals.size(); k++) begin
            t = vals[k];
            j = k - 1;
            while (j >= 0 && ranks_before(t, vals[j])) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = t;
        end
        for (int k = 0; k < vals.size(); k++)
            add_expected(vals[k], k == vals.size() - 1, batch_dropped);
        batch_vals.delete();
        batch_dropped = 0;
    endtask

    // driver: offers queued elements, random idle bursts between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap  <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                // accepted transfer: update predictor state
                if (batch_vals.size() < CAP) batch_vals.insert(batch_vals.size(), i_value_bits);
                else batch_dropped = 1;
                if (i_last_in) sort_batch_into_expected();
            end
            if (!i_valid || !o_stall) begin
                if (in_gap > 0) begin
                    in_gap  <= in_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    i_valid      <= 1'b1;
                    i_value_bits <= pending_q[0].value;
                    i_last_in    <= pending_q[0].last;
                    void'(pending_q.pop_front());
                    if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares result transfers with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            out_gap   <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected result transfer %h", o_sorted_bits);
                    errors++;
                end else begin
                    if (o_sorted_bits !== sorted_q[0].bits) begin
                        $error("sorted_bits expected %h actual %h", sorted_q[0].bits,
                               o_sorted_bits);
                        errors++;
                    end
                    if (o_last_out !== sorted_q[0].last) begin
                        $error("last_out expected %b actual %b", sorted_q[0].last, o_last_out);
                        errors++;
                    end
                    if (o_overflow !== sorted_q[0].ovf) begin
                        $error("overflow expected %b actual %b", sorted_q[0].ovf, o_overflow);
                        errors++;
                    end
                    void'(sorted_q.pop_front());
                end
            end
            // long hold-off, then random bursts
            if (hold_req && !hold_done && hold_cnt == 0) begin
                hold_cnt  <= LONG_HOLD;
                hold_done <= 1'b1;
                i_stall   <= 1'b1;
            end else if (hold_cnt > 1) begin
                hold_cnt <= hold_cnt - 1;
            end else if (hold_cnt == 1) begin
                hold_cnt <= 0;
                i_stall  <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_stall <= (out_gap > 1);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_gap <= $urandom_range(1, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // generous cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w[62:52] = 11'h7FF;             // inf / nan exponent
            1: w[62:0]  = 63'd0;               // signed zeros
            2: w[62:8]  = {2'($urandom_range(0, 3)), 53'd0};  // many equal high bytes
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_batch(int n);
        for (int k = 0; k < n; k++) add_item(rand_word(), k == n - 1);
    endtask

    // everything offered, accepted and checked
    task automatic wait_idle();
        wait (pending_q.size() == 0 && !i_valid && sorted_q.size() == 0);
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, signed zeros, nans, equal values, single element
        add_item(64'h0000_0000_0000_0000, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(64'h7FF0_0000_0000_0000, 1'b0);
        add_item(64'hFFF0_0000_0000_0000, 1'b0);
        add_item(64'h3FF0_0000_0000_0000, 1'b0);
        add_item(64'hBFF0_0000_0000_0000, 1'b0);
        add_item(64'h3FF0_0000_0000_0000, 1'b0);
        add_item(64'h0000_0000_0000_0001, 1'b0);
        add_item(64'h8000_0000_0000_0001, 1'b1);
        add_item(64'h5555_AAAA_5555_AAAA, 1'b1);
        add_item(64'hAAAA_5555_AAAA_5555, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b1);

        // overflow: capacity plus a few, closing item dropped
        queue_batch(CAP + 3);
        wait_idle();

        // receiver holds off while a batch sorts and drains, next batch waits
        hold_req = 1;
        queue_batch(6);
        queue_batch(3);
        wait_idle();

        // random small batches
        for (int b = 0; b < 3; b++) begin
            n = $urandom_range(1, 4);
            queue_batch(n);
        end
        wait (pending_q.size() == 0);
        calm = 1;
        queue_batch(4);
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && sorted_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hdl/drs_pkg.sv
hdl/drs_ram.sv
hdl/double_radix_sorter_top.sv
hdl/drs_checker.sv
dv/tb_top.sv
